FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the deque block.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/deq_pkg.sv
// Package for the deque block: field widths, operation codes and status codes.
// Depends on nothing; used by the interfaces and the top level.
`default_nettype none

package deq_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int LEN_W    = 3;
    localparam int STATUS_W = 3;
    localparam int FIELD_MAX_LEN = 4;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SMALL = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/core/deq_if.sv
// Valid/ready channel interfaces for the deque block: command and response.
// Depends on deq_pkg for the field widths.
`default_nettype none

interface deq_cmd_if;
    import deq_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [VALUE_W-1:0]  value;
    logic [LEN_W-1:0]    byte_count;

    modport source (output valid, output op, output value, output byte_count, input ready);
    modport sink   (input valid, input op, input value, input byte_count, output ready);
endinterface

interface deq_rsp_if #(
    parameter int OCC_W = 5
);
    import deq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data_out;
    logic [LEN_W-1:0]    length_out;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output data_out, output length_out,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input data_out, input length_out,
                    input occupancy, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/double_ended_queue_top.sv
// Bounded double-ended queue held in a ring buffer with byte-length tagged entries.
// Depends on deq_pkg, deq_if, deq_store and assert_macros.svh.
//
// Commands arrive on cmd and each gives exactly one response on rsp, in order.
// A command is a push, a pop or a peek at either end; other op codes are answered ST_OK and change nothing.
// Pointers and the entry count are updated in the cycle a command is transferred,
// and the store is read or written at that same edge.
// The response register is loaded from the middle stage and the registered read of the
// entry store when the middle stage advances, and rsp.valid rises with it; a command thus
// passes the middle stage and then the response register before its response is taken.
// Throughput is one command per cycle while rsp is ready; each command uses at most one
// of the store's single read port and single write port.
// When rsp stalls, the held response stays stable, one more command is taken into
// the middle stage, and cmd.ready then falls until the response is taken.
// Reset empties the queue at once and clears both pipeline stages; entry contents
// are left as they are and are never read before being written.
// The occupancy value is $clog2(DEPTH+1) bits wide; the rsp field width is the interface parameter OCC_W.
`default_nettype none

module double_ended_queue_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_BYTES = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    deq_cmd_if.sink   cmd,
    deq_rsp_if.source rsp
);
    import deq_pkg::*;
    `include "assert_macros.svh"

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int MAX_LEN = (DATA_BYTES < FIELD_MAX_LEN) ? DATA_BYTES : FIELD_MAX_LEN;
    localparam int DATA_W  = 8 * MAX_LEN;
    localparam int WORD_W  = DATA_W + LEN_W;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                reads;
        logic                peek;
        logic [LEN_W-1:0]    cap;
        logic [CNT_W-1:0]    occ;
    } s1_t;

    logic [PTR_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                s1_valid_reg;
    s1_t                 s1_reg, s1_next;
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  data_reg, data_next;
    logic [LEN_W-1:0]    length_reg, length_next;
    logic [CNT_W-1:0]    occ_reg;

    logic                s1_advance;
    logic                cmd_xfer;
    logic                is_push;
    logic                is_take;
    logic                at_back;
    logic [PTR_W-1:0]    front_dec;
    logic [PTR_W-1:0]    front_inc;
    logic [SUM_W-1:0]    tail_sum;
    logic [SUM_W-1:0]    back_sum;
    logic [PTR_W-1:0]    tail_slot;
    logic [PTR_W-1:0]    back_slot;
    logic [LEN_W-1:0]    len_sat;
    logic [DATA_W-1:0]   kept_data;

    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;
    logic [WORD_W-1:0]   rd_word;
    logic [LEN_W-1:0]    rd_len;
    logic [DATA_W-1:0]   rd_data;

    assign s1_advance = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready  = !s1_valid_reg || s1_advance;
    assign cmd_xfer   = cmd.valid && cmd.ready;

    assign is_push = (cmd.op == OP_PUSH_BACK) || (cmd.op == OP_PUSH_FRONT);
    assign is_take = (cmd.op == OP_POP_BACK) || (cmd.op == OP_POP_FRONT)
                  || (cmd.op == OP_PEEK_FRONT) || (cmd.op == OP_PEEK_BACK);
    assign at_back = (cmd.op == OP_POP_BACK) || (cmd.op == OP_PEEK_BACK);

    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    assign tail_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_sum  = tail_sum - 1'b1;
    assign tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                    : PTR_W'(tail_sum);
    assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                                    : PTR_W'(back_sum);

    assign len_sat = (cmd.byte_count > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : cmd.byte_count;

    always_comb
    begin
        for (int b = 0; b < MAX_LEN; b++)
        begin
            kept_data[8*b +: 8] = (LEN_W'(b) < len_sat) ? cmd.value[8*b +: 8] : 8'h00;
        end
    end

    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_slot;
        rd_en          = 1'b0;
        rd_addr        = front_reg;
        s1_next.status = ST_OK;
        s1_next.reads  = 1'b0;
        s1_next.peek   = (cmd.op == OP_PEEK_FRONT) || (cmd.op == OP_PEEK_BACK);
        s1_next.cap    = cmd.byte_count;
        if (is_push)
        begin
            if (cmd.byte_count == '0)
            begin
                s1_next.status = ST_ZERO;
            end
            else if (count_reg == CNT_W'(DEPTH))
            begin
                s1_next.status = ST_FULL;
            end
            else
            begin
                wr_en      = cmd_xfer;
                count_next = count_reg + 1'b1;
                if (cmd.op == OP_PUSH_FRONT)
                begin
                    wr_addr    = front_dec;
                    front_next = front_dec;
                end
            end
        end
        else if (is_take)
        begin
            if (count_reg == '0)
            begin
                s1_next.status = ST_EMPTY;
            end
            else
            begin
                s1_next.reads = 1'b1;
                rd_en         = cmd_xfer;
                rd_addr       = at_back ? back_slot : front_reg;
                if (cmd.op == OP_POP_BACK)
                begin
                    count_next = count_reg - 1'b1;
                end
                else if (cmd.op == OP_POP_FRONT)
                begin
                    count_next = count_reg - 1'b1;
                    front_next = front_inc;
                end
            end
        end
        s1_next.occ = count_next;
    end

    deq_store #(
        .DEPTH  (DEPTH),
        .WORD_W (WORD_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({len_sat, kept_data}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_len  = rd_word[WORD_W-1 -: LEN_W];
    assign rd_data = rd_word[DATA_W-1:0];

    always_comb
    begin
        status_next = s1_reg.status;
        data_next   = '0;
        length_next = '0;
        if (s1_reg.reads)
        begin
            length_next = rd_len;
            if (s1_reg.peek && (s1_reg.cap < rd_len))
            begin
                status_next = ST_SMALL;
            end
            else
            begin
                data_next = VALUE_W'(rd_data);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_xfer)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            if (cmd_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            s1_reg <= s1_next;
        end
        if (s1_advance)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            length_reg <= length_next;
            occ_reg    <= s1_reg.occ;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.data_out   = data_reg;
    assign rsp.length_out = length_reg;
    assign rsp.occupancy  = occ_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, !rst_n || (count_reg <= CNT_W'(DEPTH)), "entry count above depth")
    `ASSERT_CLK(a_count_step, clk, rst_n, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1), "entry count moved by more than one")
    `ASSERT_CLK(a_xfer_fills, clk, rst_n, cmd_xfer |=> s1_valid_reg, "transferred command lost from middle stage")
    `ASSERT_CLK(a_stall_blocks, clk, rst_n, (s1_valid_reg && rsp_valid_reg && !rsp.ready) |-> !cmd.ready, "command taken with both stages held")

endmodule

`default_nettype wire

FILE: rtl/core/deq_store.sv
// Entry store of the deque: one write port and one read port with registered read data.
// Depends on nothing; instantiated by the top level.
`default_nettype none

module deq_store #(
    parameter int DEPTH  = 16,
    parameter int WORD_W = 35
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WORD_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WORD_W-1:0]        rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: verif/deque_response_checker.sv
`timescale 1ns / 1ps
// Checker for the deque block: watches the command and response channels, predicts each
// response from its own copy of the ring buffer and compares field by field.
// Depends on deq_pkg and the channel interfaces in deq_if.
module deque_response_checker (
    input  logic clk,
    input  logic rst_n,
    deq_cmd_if   cmd,
    deq_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);
    import deq_pkg::*;

    localparam int SLOTS  = 16;
    localparam int WIDEST = 4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data;
        logic [LEN_W-1:0]    len;
        logic [4:0]          occ;
    } deq_result_t;

    logic [VALUE_W-1:0] slot_data [SLOTS];
    logic [LEN_W-1:0]   slot_len  [SLOTS];
    logic [3:0]         head;
    logic [4:0]         held;
    deq_result_t        awaited_results [$];

    function automatic deq_result_t predict_deque_op(input logic [OP_W-1:0] op,
                                                      input logic [VALUE_W-1:0] value,
                                                      input logic [LEN_W-1:0] cnt);
        deq_result_t r;
        logic [LEN_W-1:0] keep;
        logic [3:0] slot;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (cnt == 0)
                    r.status = ST_ZERO;
                else if (held == SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    keep = (cnt > WIDEST) ? LEN_W'(WIDEST) : cnt;
                    if (op == OP_PUSH_BACK)
                        slot = head + held[3:0];
                    else
                    begin
                        head = head - 1'b1;
                        slot = head;
                    end
                    slot_data[slot] = (keep >= WIDEST) ? value
                                                       : value & ((32'd1 << (8 * keep)) - 1);
                    slot_len[slot] = keep;
                    held = held + 1'b1;
                end
            end
            OP_POP_BACK, OP_POP_FRONT, OP_PEEK_FRONT, OP_PEEK_BACK:
            begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    slot = (op == OP_POP_BACK || op == OP_PEEK_BACK) ? head + held[3:0] - 1'b1
                                                                     : head;
                    r.len  = slot_len[slot];
                    r.data = slot_data[slot];
                    if ((op == OP_PEEK_FRONT || op == OP_PEEK_BACK) && cnt < r.len)
                    begin
                        r.status = ST_SMALL;
                        r.data   = '0;
                    end
                    else if (op == OP_POP_BACK)
                        held = held - 1'b1;
                    else if (op == OP_POP_FRONT)
                    begin
                        head = head + 1'b1;
                        held = held - 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.occ = held;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: deque response mismatch on %s: got %0h, expected %0h",
                 $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deq_result_t want;
        if (!rst_n)
        begin
            head        = '0;
            held        = '0;
            mismatches  = 0;
            outstanding <= 0;
            awaited_results.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("unexpected transfer (status)", 32'(rsp.status), '0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.data_out !== want.data)
                        report_mismatch("data_out", rsp.data_out, want.data);
                    if (rsp.length_out !== want.len)
                        report_mismatch("length_out", 32'(rsp.length_out), 32'(want.len));
                    if (rsp.occupancy !== want.occ)
                        report_mismatch("occupancy", 32'(rsp.occupancy), 32'(want.occ));
                end
            end
            if (cmd.valid && cmd.ready)
                awaited_results.push_back(predict_deque_op(cmd.op, cmd.value, cmd.byte_count));
            outstanding <= awaited_results.size();
        end
    end
endmodule

FILE: verif/double_ended_queue_top_test.sv
`timescale 1ns / 1ps
// Top of the deque testbench: clock, reset, command stimulus and response back-pressure.
// Depends on deq_pkg, deq_if, double_ended_queue_top and deque_response_checker.
module double_ended_queue_top_test;
    import deq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 120;
    localparam int PHASE_ITEMS    = 300;
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam logic [OP_W-1:0] READ_OPS [4] =
        '{OP_POP_BACK, OP_POP_FRONT, OP_PEEK_FRONT, OP_PEEK_BACK};

    logic clk           = 1'b0;
    logic rst_n         = 1'b0;
    logic long_hold_req = 1'b0;
    int   send_idle_pct = 19;
    int   recv_idle_pct = 59;
    int   quiet_cycles  = 0;
    int   mismatches;
    int   outstanding;

    deq_cmd_if cmd ();
    deq_rsp_if #(.OCC_W(5)) rsp ();

    double_ended_queue_top #(
        .DEPTH(16),
        .DATA_BYTES(4)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .rsp(rsp)
    );

    deque_response_checker response_check (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .rsp(rsp),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("double_ended_queue_top_test: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : response_taker
        int   hold_left;
        logic hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                            input logic [LEN_W-1:0] cnt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.op         <= op;
        cmd.value      <= value;
        cmd.byte_count <= cnt;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    task automatic send_random(input int push_pct);
        int               pick;
        logic [OP_W-1:0]  op;
        logic [LEN_W-1:0] cnt;
        pick = $urandom_range(99);
        cnt  = LEN_W'($urandom_range(7));
        if (pick < push_pct)
        begin
            op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            if ($urandom_range(7) != 0)
                cnt = LEN_W'($urandom_range(1, 4));
        end
        else if (pick < 97)
            op = READ_OPS[$urandom_range(3)];
        else
            op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
        send_cmd(op, $urandom, cnt);
    endtask

    task automatic wait_drained();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int sent;
        int push_pct;
        cmd.valid      <= 1'b0;
        cmd.op         <= OP_PUSH_BACK;
        cmd.value      <= '0;
        cmd.byte_count <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(OP_POP_BACK, '0, 3'd0);
        send_cmd(OP_POP_FRONT, '0, 3'd0);
        send_cmd(OP_PEEK_FRONT, '0, 3'd7);
        send_cmd(OP_PEEK_BACK, '0, 3'd7);
        send_cmd(OP_PUSH_BACK, 32'hFFFF_FFFF, 3'd0);
        send_cmd(OP_SPARE_LO, 32'hFFFF_FFFF, 3'd7);
        send_cmd(OP_SPARE_HI, '0, 3'd0);
        send_cmd(OP_PUSH_BACK, 32'hFFFF_FFFF, 3'd7);
        send_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFF, 3'd1);
        send_cmd(OP_PEEK_FRONT, '0, 3'd0);
        send_cmd(OP_PEEK_BACK, '0, 3'd3);
        send_cmd(OP_PEEK_BACK, '0, 3'd7);
        for (int i = 0; i < 14; i++)
            send_cmd(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom,
                     LEN_W'($urandom_range(1, 4)));
        send_cmd(OP_PUSH_FRONT, $urandom, 3'd2);
        send_cmd(OP_PUSH_BACK, $urandom, 3'd0);
        send_cmd(OP_POP_FRONT, '0, 3'd0);
        send_cmd(OP_POP_BACK, '0, 3'd0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 19;
                    recv_idle_pct = 59;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_idle_pct = 19;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    long_hold_req <= 1'b1;
                end
            endcase
            sent = 0;
            if (phase == 2)
            begin
                repeat (40) send_random(85);
                sent = 40;
            end
            while (sent < PHASE_ITEMS)
            begin
                push_pct = $urandom_range(20, 80);
                repeat (30) send_random(push_pct);
                sent += 30;
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("double_ended_queue_top_test: PASS");
        else
            $display("double_ended_queue_top_test: FAIL");
        $finish;
    end
endmodule
